/* rtl/core/bdsf_pkg.sv */
// Package for the block data stream framer: command and register codes,
// character encoding constants, state type and inter-module structs.
// No dependencies.
package bdsf_pkg;

    // Default block buffer size in bytes
    localparam int DEF_BLOCK_BYTES = 256;

    // Item commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_UTF   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_MODE  = 2'd3;

    // Configuration register indexes
    localparam logic REG_SHORT_TAG = 1'b0;
    localparam logic REG_LONG_TAG  = 1'b1;

    // Tag reset values
    localparam logic [7:0] SHORT_TAG_RST = 8'd119;
    localparam logic [7:0] LONG_TAG_RST  = 8'd122;

    // Modified UTF-8 encoding
    localparam logic [15:0] UTF_ONE_MAX = 16'h007F;
    localparam logic [15:0] UTF_TWO_MAX = 16'h07FF;
    localparam logic [7:0]  UTF_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF_CONT    = 8'h80;

    // Header sizes in bytes
    localparam logic [3:0] HDR_SHORT_BYTES = 4'd2;
    localparam logic [3:0] HDR_LONG_BYTES  = 4'd5;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_DSTART,
        ST_HDR,
        ST_RISSUE,
        ST_RWAIT
    } state_t;

    // Word handed to the output register
    typedef struct packed {
        logic        load;
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        hdr;
        logic        last;
    } emit_t;

    // Block store access strobes
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

endpackage

/* rtl/core/bdsf_encode.sv */
// Turns one input item into up to eight left-aligned bytes to append:
// big-endian value bytes or a modified UTF-8 character.
// Depends on bdsf_pkg.
module bdsf_encode
    import bdsf_pkg::*;
(
    input  logic [1:0]  cmd,
    input  logic [63:0] value,
    input  logic [3:0]  byte_count,
    output logic [63:0] enc_bytes,
    output logic [3:0]  enc_count
);

    logic [3:0]  cnt;
    logic [6:0]  shamt;
    logic [15:0] c;

    assign cnt   = (byte_count > 4'd8) ? 4'd8 : byte_count;
    assign shamt = {4'd8 - cnt, 3'b000};
    assign c     = value[15:0];

    // Byte list per command
    always_comb
    begin
        enc_bytes = 64'd0;
        enc_count = 4'd0;
        unique case (cmd)
            CMD_WRITE:
            begin
                enc_bytes = value << shamt;
                enc_count = cnt;
            end
            CMD_UTF:
            begin
                if (c >= 16'h0001 && c <= UTF_ONE_MAX)
                begin
                    enc_bytes = {c[7:0], 56'd0};
                    enc_count = 4'd1;
                end
                else if (c > UTF_TWO_MAX)
                begin
                    enc_bytes = {UTF_LEAD3 | {4'd0, c[15:12]},
                                 UTF_CONT | {2'd0, c[11:6]},
                                 UTF_CONT | {2'd0, c[5:0]}, 40'd0};
                    enc_count = 4'd3;
                end
                else
                begin
                    // NUL lands here too: 0xC0 0x80
                    enc_bytes = {UTF_LEAD2 | {3'd0, c[10:6]},
                                 UTF_CONT | {2'd0, c[5:0]}, 48'd0};
                    enc_count = 4'd2;
                end
            end
            default:
            begin
                enc_bytes = 64'd0;
                enc_count = 4'd0;
            end
        endcase
    end

endmodule

/* rtl/core/bdsf_store.sv */
// Block store: rows of eight bytes, byte-lane write, one registered row read.
// Depends on bdsf_pkg.
module bdsf_store
    import bdsf_pkg::*;
#(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
)
(
    input  logic                              clk,
    input  mem_ctrl_t                         mem,
    input  logic [$clog2(BLOCK_BYTES)-1:0]    waddr,
    input  logic [7:0]                        wdata,
    input  logic [$clog2(BLOCK_BYTES)-4:0]    raddr,
    output logic [63:0]                       rdata
);

    localparam int ROWS = (BLOCK_BYTES + 7) / 8;
    localparam int AW   = $clog2(BLOCK_BYTES);

    logic [63:0] mem_array [ROWS];
    logic [63:0] rdata_reg;

    // Byte write, lane 0 is the most significant byte of the row
    always_ff @(posedge clk)
    begin
        if (mem.we)
        begin
            mem_array[waddr[AW-1:3]][{3'd7 - waddr[2:0], 3'b000} +: 8] <= wdata;
        end
    end

    // Registered row read
    always_ff @(posedge clk)
    begin
        if (mem.re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bdsf_ctrl.sv */
// Framer sequencer: appends bytes to the block store one per cycle, pausing to
// drain when the block fills, and drains it as an optional header plus data words. Depends on bdsf_pkg.
module bdsf_ctrl
    import bdsf_pkg::*;
#(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic                              mode_bit,
    input  logic [63:0]                       enc_bytes,
    input  logic [3:0]                        enc_count,
    input  logic [7:0]                        short_tag,
    input  logic [7:0]                        long_tag,
    input  logic                              out_free,
    output emit_t                             emit,
    output mem_ctrl_t                         mem,
    output logic [$clog2(BLOCK_BYTES)-1:0]    waddr,
    output logic [7:0]                        wdata,
    output logic [$clog2(BLOCK_BYTES)-4:0]    raddr,
    input  logic [63:0]                       rdata
);

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int FW = $clog2(BLOCK_BYTES + 1);

    state_t          state_reg, state_next, ret_state;
    logic [1:0]      cmd_reg;
    logic            mode_reg;
    logic [63:0]     bytes_reg;
    logic [3:0]      nb_reg;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   pos_reg;
    logic            block_mode_reg;

    logic            accept;
    logic            full;
    logic [FW-1:0]   rem;
    logic            rem_last;
    logic [3:0]      n;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign full      = (fill_reg == FW'(BLOCK_BYTES));
    assign rem       = fill_reg - pos_reg;
    assign rem_last  = (rem <= FW'(8));
    assign n         = rem_last ? rem[3:0] : 4'd8;
    assign ret_state = (cmd_reg == CMD_WRITE || cmd_reg == CMD_UTF) ? ST_APPEND : ST_IDLE;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_WRITE || cmd == CMD_UTF)
                        state_next = ST_APPEND;
                    else if (cmd == CMD_FLUSH)
                        state_next = ST_DSTART;
                    else if (mode_bit != block_mode_reg)
                        state_next = ST_DSTART;
                end
            end
            ST_APPEND:
            begin
                if (nb_reg == 4'd0)
                    state_next = ST_IDLE;
                else if (full)
                    state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                if (fill_reg == '0)
                    state_next = ret_state;
                else if (block_mode_reg)
                    state_next = ST_HDR;
                else
                    state_next = ST_RISSUE;
            end
            ST_HDR:
            begin
                if (out_free)
                    state_next = ST_RISSUE;
            end
            ST_RISSUE:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (out_free)
                    state_next = rem_last ? ret_state : ST_RISSUE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: store strobes and output words
    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        mem.we      = (state_reg == ST_APPEND) && (nb_reg != 4'd0) && !full;
        mem.re      = (state_reg == ST_RISSUE);
        waddr       = fill_reg[AW-1:0];
        wdata       = bytes_reg[63:56];
        raddr       = pos_reg[AW-1:3];
        emit.load   = 1'b0;
        emit.word   = 64'd0;
        emit.nbytes = 4'd0;
        emit.hdr    = 1'b0;
        emit.last   = 1'b0;
        unique case (state_reg)
            ST_HDR:
            begin
                emit.load = out_free;
                emit.hdr  = 1'b1;
                if (32'(fill_reg) > 32'd255)
                begin
                    emit.word   = {24'd0, long_tag, 32'(fill_reg)};
                    emit.nbytes = HDR_LONG_BYTES;
                end
                else
                begin
                    emit.word   = {48'd0, short_tag, fill_reg[7:0]};
                    emit.nbytes = HDR_SHORT_BYTES;
                end
            end
            ST_RWAIT:
            begin
                // right-align the row's first n bytes
                emit.load   = out_free;
                emit.word   = rdata >> {4'd8 - n, 3'b000};
                emit.nbytes = n;
                emit.last   = rem_last;
            end
            default:
            begin
                emit.load = 1'b0;
            end
        endcase
    end

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= CMD_WRITE;
            mode_reg       <= 1'b0;
            bytes_reg      <= 64'd0;
            nb_reg         <= 4'd0;
            fill_reg       <= '0;
            pos_reg        <= '0;
            block_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // latch item
            if (accept)
            begin
                cmd_reg   <= cmd;
                mode_reg  <= mode_bit;
                bytes_reg <= enc_bytes;
                nb_reg    <= enc_count;
            end

            // append one byte
            if (mem.we)
            begin
                bytes_reg <= {bytes_reg[55:0], 8'd0};
                nb_reg    <= nb_reg - 4'd1;
                fill_reg  <= fill_reg + FW'(1);
            end

            if (state_reg == ST_DSTART)
                pos_reg <= '0;

            // advance drain; buffer empties after the final word
            if (state_reg == ST_RWAIT && out_free)
            begin
                pos_reg <= pos_reg + FW'(8);
                if (rem_last)
                    fill_reg <= '0;
            end

            // new mode takes effect once the old-mode drain is done
            if (state_reg != ST_IDLE && state_next == ST_IDLE && cmd_reg == CMD_MODE)
                block_mode_reg <= mode_reg;
        end
    end

endmodule

/* rtl/core/block_data_stream_framer.sv */
// Block data stream framer, top level. An item is accepted only in idle; its bytes
// are then appended one per cycle, pausing to drain when the block fills, and the
// input is stalled until the controller is back in idle. A drain passes a start
// state, a header word in block mode, and per data word a row read then an output
// load, set by the single read port of the block store. One item at a time.
// Reset (async, active low) clears control state, sets the tags to 119/122.
module block_data_stream_framer
    import bdsf_pkg::*;
#(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [63:0] value,
    input  logic [3:0]  byte_count,
    input  logic        mode_bit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_word,
    output logic [3:0]  out_bytes,
    output logic        is_header,
    output logic        last
);

    localparam int AW = $clog2(BLOCK_BYTES);

    logic [7:0]    short_tag_reg;
    logic [7:0]    long_tag_reg;
    logic [63:0]   enc_bytes;
    logic [3:0]    enc_count;
    emit_t         emit;
    mem_ctrl_t     mem;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-4:0] raddr;
    logic [63:0]   rdata;
    logic          out_free;

    logic          out_valid_reg;
    logic [63:0]   out_word_reg;
    logic [3:0]    out_bytes_reg;
    logic          is_header_reg;
    logic          last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_tag_reg <= SHORT_TAG_RST;
            long_tag_reg  <= LONG_TAG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_TAG: short_tag_reg <= cfg_data;
                REG_LONG_TAG:  long_tag_reg  <= cfg_data;
                default:       short_tag_reg <= short_tag_reg;
            endcase
        end
    end

    bdsf_encode u_encode (
        .cmd        (cmd),
        .value      (value),
        .byte_count (byte_count),
        .enc_bytes  (enc_bytes),
        .enc_count  (enc_count)
    );

    bdsf_ctrl #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .mode_bit  (mode_bit),
        .enc_bytes (enc_bytes),
        .enc_count (enc_count),
        .short_tag (short_tag_reg),
        .long_tag  (long_tag_reg),
        .out_free  (out_free),
        .emit      (emit),
        .mem       (mem),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    bdsf_store #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_store (
        .clk   (clk),
        .mem   (mem),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Output register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_word_reg  <= emit.word;
            out_bytes_reg <= emit.nbytes;
            is_header_reg <= emit.hdr;
            last_reg      <= emit.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_bytes = out_bytes_reg;
    assign is_header = is_header_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // a word is loaded only into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> out_free)
        else $error("output word loaded over a pending word");

    // header words are two or five bytes and never end a drain
    a_hdr_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_header) |->
            (!last && (out_bytes == HDR_SHORT_BYTES || out_bytes == HDR_LONG_BYTES)))
        else $error("malformed header word");

    // data words carry one to eight bytes
    a_data_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_header) |-> (out_bytes >= 4'd1 && out_bytes <= 4'd8))
        else $error("data word byte count out of range");

    // store is never written and read in the same cycle
    a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem.we && mem.re))
        else $error("store written and read together");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for block_data_stream_framer: directed and random items,
// random idling on both channels and a framing predictor that checks every output word.
// Depends on bdsf_pkg and the framer RTL.
module tb_top;
    import bdsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK_BYTES     = DEF_BLOCK_BYTES;
    localparam int SHORT_LEN_MAX = 255;
    localparam int WORD_BYTES    = 8;
    localparam int SETTLE_CYCLES = 100;     // drain of a full block plus a few appends
    localparam int HOLD_CYCLES   = 600;     // long receiver hold-off
    localparam int CYCLE_LIMIT   = 2000000;

    // Idle styles for either side
    localparam int GAP_NONE   = 0;
    localparam int GAP_FULL   = 1;
    localparam int GAP_SPARSE = 2;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] val;
        logic [3:0]  cnt;
        logic        mode;
    } item_t;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        hdr;
        logic        last;
    } frame_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_WRITE;
    logic [63:0] value = 64'd0;
    logic [3:0]  byte_count = 4'd0;
    logic        mode_bit = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        is_header;
    logic        last;

    block_data_stream_framer #(.BLOCK_BYTES(BLK_BYTES)) dut (.*);

    // Predictor state
    logic [7:0] blk_mem [BLK_BYTES];
    int         fill_cnt = 0;
    logic       mode_now = 1'b0;
    logic [7:0] tag_short = SHORT_TAG_RST;
    logic [7:0] tag_long = LONG_TAG_RST;

    item_t       item_q [$];
    frame_word_t frame_q [$];

    int items_queued = 0;
    int items_sent = 0;
    int words_seen = 0;
    int hdr_seen = 0;
    int long_hdr_seen = 0;
    int err_count = 0;
    int cycles = 0;
    int tx_style = GAP_FULL;
    int rx_style = GAP_FULL;
    int tx_cnt = 0;
    int rx_cnt = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cnt = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int draw_gap(int style);
        case (style)
            GAP_NONE: return 0;
            GAP_FULL: return $urandom_range(0, 11);
            default:  return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
        endcase
    endfunction

    // Emit the buffered block: optional header, then data words of up to eight bytes
    function automatic void drain_block();
        frame_word_t w;
        int n;
        if (fill_cnt == 0)
            return;
        if (mode_now)
        begin
            w.hdr = 1'b1;
            w.last = 1'b0;
            if (fill_cnt <= SHORT_LEN_MAX)
            begin
                w.word = {48'd0, tag_short, 8'(fill_cnt)};
                w.nbytes = HDR_SHORT_BYTES;
            end
            else
            begin
                w.word = {24'd0, tag_long, 32'(fill_cnt)};
                w.nbytes = HDR_LONG_BYTES;
            end
            frame_q.push_back(w);
        end
        for (int i = 0; i < fill_cnt; i += WORD_BYTES)
        begin
            n = (fill_cnt - i > WORD_BYTES) ? WORD_BYTES : fill_cnt - i;
            w.word = '0;
            for (int j = 0; j < n; j++)
                w.word = {w.word[55:0], blk_mem[i + j]};
            w.nbytes = 4'(n);
            w.hdr = 1'b0;
            w.last = (i + n >= fill_cnt);
            frame_q.push_back(w);
        end
        fill_cnt = 0;
    endfunction

    function automatic void append_byte(logic [7:0] b);
        if (fill_cnt >= BLK_BYTES)
            drain_block();
        blk_mem[fill_cnt % BLK_BYTES] = b;
        fill_cnt++;
    endfunction

    // Expected output words caused by one accepted item
    function automatic void predict_item(logic [1:0] op, logic [63:0] val,
                                         logic [3:0] cnt, logic mb);
        int n;
        logic [15:0] ch;
        case (op)
            CMD_WRITE:
            begin
                n = (cnt > WORD_BYTES) ? WORD_BYTES : cnt;
                for (int i = n; i > 0; i--)
                    append_byte(val[(i - 1) * 8 +: 8]);
            end
            CMD_UTF:
            begin
                ch = val[15:0];
                if (ch != 16'd0 && ch <= UTF_ONE_MAX)
                begin
                    append_byte(ch[7:0]);
                end
                else if (ch > UTF_TWO_MAX)
                begin
                    append_byte(UTF_LEAD3 | {4'd0, ch[15:12]});
                    append_byte(UTF_CONT | {2'd0, ch[11:6]});
                    append_byte(UTF_CONT | {2'd0, ch[5:0]});
                end
                else
                begin
                    // NUL lands here too: 0xC0 0x80
                    append_byte(UTF_LEAD2 | {3'd0, ch[10:6]});
                    append_byte(UTF_CONT | {2'd0, ch[5:0]});
                end
            end
            CMD_FLUSH: drain_block();
            CMD_MODE:
            begin
                if (mb != mode_now)
                begin
                    drain_block();
                    mode_now = mb;
                end
            end
        endcase
    endfunction

    function automatic item_t mk_item(logic [1:0] op, logic [63:0] val,
                                      logic [3:0] cnt, logic mb);
        item_t it;
        it.op = op;
        it.val = val;
        it.cnt = cnt;
        it.mode = mb;
        return it;
    endfunction

    // Random item; ctrl_pct sets the share of flush and mode items
    function automatic item_t rand_item(int ctrl_pct);
        item_t it;
        int r;
        it.val = {$urandom, $urandom};
        it.cnt = 4'($urandom_range(1, 8));
        it.mode = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < ctrl_pct)
        begin
            it.op = ($urandom_range(0, 1) == 1) ? CMD_FLUSH : CMD_MODE;
        end
        else if (r < ctrl_pct + (100 - ctrl_pct) / 3)
        begin
            it.op = CMD_UTF;
            case ($urandom_range(0, 7))
                0:       it.val[15:0] = 16'd0;
                1, 2:    it.val[15:0] = 16'($urandom_range(1, 16'h007F));
                3, 4:    it.val[15:0] = 16'($urandom_range(16'h0080, 16'h07FF));
                default: it.val[15:0] = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
        end
        else
        begin
            it.op = CMD_WRITE;
            if ($urandom_range(0, 15) == 0)
                it.cnt = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(9, 15));
        end
        return it;
    endfunction

    function automatic void send(item_t it);
        item_q.push_back(it);
        items_queued++;
    endfunction

    // Sender pauses until all items are taken and all words are back
    task automatic wait_idle();
        while (items_sent != items_queued || frame_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SHORT_TAG)
            tag_short = data;
        else
            tag_long = data;
    endtask

    // Input driver: offers queued items, holds payload while stalled
    always @(posedge clk)
    begin : drv
        item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_cnt <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_item(cmd, value, byte_count, mode_bit);
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_cnt != 0)
                begin
                    tx_cnt <= tx_cnt - 1;
                    in_valid <= 1'b0;
                end
                else if (item_q.size() != 0)
                begin
                    it = item_q.pop_front();
                    cmd <= it.op;
                    value <= it.val;
                    byte_count <= it.cnt;
                    mode_bit <= it.mode;
                    in_valid <= 1'b1;
                    tx_cnt <= draw_gap(tx_style);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver stall
    always @(posedge clk)
    begin : mon
        frame_word_t e;
        int gap;
        logic took;
        took = out_valid && !out_stall;
        if (rst_n && took)
        begin
            words_seen++;
            if (is_header)
                hdr_seen++;
            if (is_header && out_bytes == HDR_LONG_BYTES)
                long_hdr_seen++;
            if (frame_q.size() == 0)
            begin
                flag_error($sformatf("unexpected word %h bytes %0d",
                                     out_word, out_bytes));
            end
            else
            begin
                e = frame_q.pop_front();
                if (out_word !== e.word)
                    flag_error($sformatf("out_word %h, want %h", out_word, e.word));
                if (out_bytes !== e.nbytes)
                    flag_error($sformatf("out_bytes %0d, want %0d", out_bytes, e.nbytes));
                if (is_header !== e.hdr)
                    flag_error($sformatf("is_header %b, want %b", is_header, e.hdr));
                if (last !== e.last)
                    flag_error($sformatf("last %b, want %b", last, e.last));
            end
        end
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= (hold_cnt != 1);
        end
        else if (rx_cnt != 0)
        begin
            rx_cnt <= rx_cnt - 1;
            out_stall <= (rx_cnt != 1);
        end
        else if (took)
        begin
            gap = draw_gap(rx_style);
            rx_cnt <= gap;
            out_stall <= (gap != 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus phases
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, all commands, character classes, mode handling
        send(mk_item(CMD_FLUSH, 64'd0, 4'd1, 1'b0));                 // empty drain
        send(mk_item(CMD_WRITE, '1, 4'd8, 1'b1));
        send(mk_item(CMD_WRITE, 64'd0, 4'd1, 1'b0));
        send(mk_item(CMD_WRITE, 64'hA5A5_5A5A_A5A5_5A5A, 4'd0, 1'b0)); // zero count
        send(mk_item(CMD_WRITE, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b1)); // clipped to 8
        send(mk_item(CMD_UTF, 64'hFFFF_FFFF_FFFF_0000, 4'd0, 1'b0));   // NUL
        send(mk_item(CMD_UTF, 64'h0001, 4'd3, 1'b0));
        send(mk_item(CMD_UTF, 64'h007F, 4'd3, 1'b0));
        send(mk_item(CMD_UTF, 64'h0080, 4'd3, 1'b0));
        send(mk_item(CMD_UTF, 64'h07FF, 4'd3, 1'b0));
        send(mk_item(CMD_UTF, 64'h0800, 4'd3, 1'b0));
        send(mk_item(CMD_UTF, 64'hFFFF, 4'd3, 1'b0));
        send(mk_item(CMD_FLUSH, 64'd0, 4'd1, 1'b1));
        send(mk_item(CMD_MODE, 64'd0, 4'd1, 1'b0));                  // mode unchanged
        send(mk_item(CMD_WRITE, 64'h8000_0000_0000_0001, 4'd8, 1'b0));
        send(mk_item(CMD_MODE, 64'd0, 4'd1, 1'b1));                  // drains raw
        send(mk_item(CMD_WRITE, 64'h1234, 4'd2, 1'b0));
        send(mk_item(CMD_FLUSH, 64'd0, 4'd1, 1'b0));                 // short header
        send(mk_item(CMD_MODE, 64'd0, 4'd1, 1'b1));                  // mode unchanged
        send(mk_item(CMD_WRITE, 64'hABCDEF, 4'd3, 1'b0));
        send(mk_item(CMD_MODE, 64'd0, 4'd1, 1'b0));                  // drains with header
        wait_idle();

        // Mixed traffic, random tags, gaps everywhere
        write_reg(REG_SHORT_TAG, 8'($urandom));
        write_reg(REG_LONG_TAG, 8'($urandom));
        repeat (80) send(rand_item(15));
        wait_idle();

        // Long blocks, starting in block mode, zero tags, no idling
        write_reg(REG_SHORT_TAG, 8'h00);
        write_reg(REG_LONG_TAG, 8'h00);
        tx_style = GAP_NONE;
        rx_style = GAP_NONE;
        send(mk_item(CMD_MODE, 64'd0, 4'd1, 1'b1));
        repeat (80) send(rand_item(2));
        wait_idle();

        // Backpressure: receiver holds off while full-width writes keep coming
        write_reg(REG_SHORT_TAG, 8'hFF);
        write_reg(REG_LONG_TAG, 8'hFF);
        rx_style = GAP_SPARSE;
        send(mk_item(CMD_MODE, 64'd0, 4'd1, 1'b1));
        hold_req <= hold_req + 1;
        repeat (60) send(mk_item(CMD_WRITE, {$urandom, $urandom}, 4'd8,
                                 1'($urandom_range(0, 1))));
        wait_idle();

        write_reg(REG_SHORT_TAG, 8'($urandom));
        write_reg(REG_LONG_TAG, 8'($urandom));
        tx_style = GAP_SPARSE;
        rx_style = GAP_FULL;
        repeat (120) send(rand_item(5));
        wait_idle();

        write_reg(REG_LONG_TAG, 8'($urandom));
        tx_style = GAP_FULL;
        rx_style = GAP_SPARSE;
        repeat (110) send(rand_item(10));
        wait_idle();

        $display("Covered %0d items over six tag settings; checked %0d output words,",
                 items_sent, words_seen);
        $display("%0d of them block headers (%0d with a four-byte length), %0d mismatches.",
                 hdr_seen, long_hdr_seen, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/core/bdsf_pkg.sv
rtl/core/bdsf_encode.sv
rtl/core/bdsf_store.sv
rtl/core/bdsf_ctrl.sv
rtl/core/block_data_stream_framer.sv
tb/tb_top.sv
